// ----- design/sawtooth_window_correlator_top_assert.svh -----
// Assertion macros for the sawtooth window correlator checker.
// Needs nothing else; included by the checker file.
`ifndef SAWTOOTH_WINDOW_CORRELATOR_TOP_ASSERT_SVH
`define SAWTOOTH_WINDOW_CORRELATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/swc_pkg.sv -----
// Shared types and constants of the sawtooth window correlator.
// No dependencies; compiled before every other design file.
package swc_pkg;

  localparam int unsigned WIN_W      = 11;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned START_W    = 17;
  localparam int unsigned SAW_W      = 18;
  localparam int unsigned OUT_W      = 44;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [WIN_W-1:0]         WIN_RESET  = 11'd64;
  localparam logic [STEP_W-1:0]        STEP_RESET = 16'd2048;
  localparam logic signed [SAW_W-1:0]  IMAG_RESET = -18'sd16384;
  localparam logic signed [SAW_W-1:0]  SAW_NEG_FS = -18'sd32768;
  localparam logic signed [SAW_W-1:0]  SAW_WRAP   = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_PHASE_STEP    = 2'd1,
    CFG_IMAG_START    = 2'd2
  } cfg_idx_e;

  // Pipeline events that steer the product history.
  typedef struct packed {
    logic clear;     // window rewrite: history empties
    logic push;      // input beat accepted
    logic s2_valid;  // product stage holds an item
    logic adv2;      // input stage moves to product stage
    logic adv3;      // product stage moves to output stage
  } hist_ctrl_t;

endpackage

// ----- design/swc_if.sv -----
// Channel interfaces of the sawtooth window correlator: samples, results, config.
// Depends on swc_pkg.
interface swc_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [swc_pkg::OUT_W-1:0]  sum_real;
  logic signed [swc_pkg::OUT_W-1:0]  sum_imag;

  modport source (output valid, output sum_real, output sum_imag, input ready);
  modport sink   (input valid, input sum_real, input sum_imag, output ready);
endinterface

interface swc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [swc_pkg::CFG_IDX_W-1:0]     index;
  logic [swc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/swc_saw_gen.sv -----
// In-phase and quadrature sawtooth reference generators.
// Depends on swc_pkg.
module swc_saw_gen (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  logic [swc_pkg::STEP_W-1:0]          step_i,
  input  logic                                restart_i,
  input  logic signed [swc_pkg::START_W-1:0]  start_i,
  output logic signed [swc_pkg::SAW_W-1:0]    saw_real_o,
  output logic signed [swc_pkg::SAW_W-1:0]    saw_imag_o
);
  import swc_pkg::*;

  logic signed [SAW_W-1:0] saw_real_q, saw_imag_q;
  logic signed [SAW_W-1:0] step_s;

  // A reference below negative full scale wraps up by two full scales before use.
  assign saw_real_o = (saw_real_q < SAW_NEG_FS) ? saw_real_q + SAW_WRAP : saw_real_q;
  assign saw_imag_o = (saw_imag_q < SAW_NEG_FS) ? saw_imag_q + SAW_WRAP : saw_imag_q;
  assign step_s     = $signed({2'b00, step_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_real_q <= '0;
      saw_imag_q <= IMAG_RESET;
    end else if (restart_i) begin
      saw_real_q <= '0;
      saw_imag_q <= SAW_W'(start_i);
    end else if (advance_i) begin
      saw_real_q <= saw_real_o - step_s;
      saw_imag_q <= saw_imag_o - step_s;
    end
  end

endmodule

// ----- design/swc_win_mem.sv -----
// Product history memory with write pointer, fill count and write-to-read forwarding.
// Depends on swc_pkg.
module swc_win_mem #(
  parameter int unsigned MAX_WINDOW = 1024,
  parameter int unsigned PROD_W     = 34
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  swc_pkg::hist_ctrl_t                   ctrl_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       len_i,
  input  logic signed [PROD_W-1:0]              wr_re_i,
  input  logic signed [PROD_W-1:0]              wr_im_i,
  output logic signed [PROD_W-1:0]              old_re_o,
  output logic signed [PROD_W-1:0]              old_im_o
);
  import swc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW    = $clog2(MAX_WINDOW);

  logic [2*PROD_W-1:0] mem_q [MAX_WINDOW];
  logic [2*PROD_W-1:0] rd_q;
  logic [2*PROD_W-1:0] fwd_q;

  logic [PW-1:0]    ptr_q;
  logic [LEN_W-1:0] fill_q;
  logic [LEN_W:0]   base;
  logic [PW-1:0]    old_addr;
  logic             old_live;

  logic [PW-1:0] s1_raddr_q, s1_wptr_q, s2_wptr_q;
  logic          s1_live_q, s2_live_q, s2_fwd_q;

  // Entry that leaves the window, taken modulo the history depth.
  always_comb begin
    base = (LEN_W+1)'(ptr_q);
    if ((LEN_W+1)'(ptr_q) < (LEN_W+1)'(len_i)) begin
      base = (LEN_W+1)'(ptr_q) + (LEN_W+1)'(MAX_WINDOW);
    end
    old_addr = PW'(base - (LEN_W+1)'(len_i));
  end

  // The leaving entry exists only once a full window has been written since clear.
  assign old_live = (fill_q >= len_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else if (ctrl_i.clear) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else if (ctrl_i.push) begin
      ptr_q  <= (ptr_q == PW'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      fill_q <= (fill_q == LEN_W'(MAX_WINDOW)) ? fill_q : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      s1_raddr_q <= old_addr;
      s1_live_q  <= old_live;
      s1_wptr_q  <= ptr_q;
    end
    if (ctrl_i.adv2) begin
      s2_wptr_q <= s1_wptr_q;
      s2_live_q <= s1_live_q;
      // The item ahead writes its product on this same edge when the window is one long.
      s2_fwd_q  <= ctrl_i.s2_valid && (s2_wptr_q == s1_raddr_q);
      fwd_q     <= {wr_re_i, wr_im_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv3) begin
      mem_q[s2_wptr_q] <= {wr_re_i, wr_im_i};
    end
    if (ctrl_i.adv2) begin
      rd_q <= mem_q[s1_raddr_q];
    end
  end

  always_comb begin
    old_re_o = '0;
    old_im_o = '0;
    if (s2_live_q) begin
      if (s2_fwd_q) begin
        old_re_o = $signed(fwd_q[2*PROD_W-1:PROD_W]);
        old_im_o = $signed(fwd_q[PROD_W-1:0]);
      end else begin
        old_re_o = $signed(rd_q[2*PROD_W-1:PROD_W]);
        old_im_o = $signed(rd_q[PROD_W-1:0]);
      end
    end
  end

endmodule

// ----- design/sawtooth_window_correlator_top.sv -----
// Top level of the sawtooth window correlator: config registers, pipeline, accumulators.
// Depends on swc_pkg, swc_if, swc_saw_gen and swc_win_mem.
//
//   channel    dir  payload                         beat when
//   cfg_i      in   index, data                     cfg_i.valid && cfg_i.ready
//   sample_i   in   sample (SAMPLE_BITS, signed)    sample_i.valid && sample_i.ready
//   result_o   out  sum_real, sum_imag (44, sgn)    result_o.valid && result_o.ready
//
// Throughput is one sample beat per clock while result beats are not stalled; each result
// is valid after passing an input stage, a multiply stage and the accumulator stage.
// The multiply stage (SAMPLE_BITS by 18 bits) and the history memory read set the
// stage boundaries. Reset clears the pipeline, the pointers and the sums; the history
// memory is never swept, a fill count marks which entries are live. When the result
// beat is stalled the pipeline holds and takes new samples until all stages are full.
module sawtooth_window_correlator_top #(
  parameter int unsigned MAX_WINDOW  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swc_cfg_if.sink     cfg_i,
  swc_sample_if.sink  sample_i,
  swc_result_if.source result_o
);
  import swc_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PROD_W = SAMPLE_BITS + SAW_W;

  // Configuration registers. Writes must arrive only while the block is idle; the user is
  // bound to this, the block itself does not enforce it, and the port is always ready.
  logic [WIN_W-1:0]  win_len_q;
  logic [STEP_W-1:0] step_q;
  cfg_idx_e          cfg_idx;
  logic              clear_win;
  logic              restart_saw;
  logic [LEN_W-1:0]  eff_len;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_i.index);

  always_comb begin
    clear_win   = 1'b0;
    restart_saw = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_idx)
        CFG_WINDOW_LENGTH: clear_win   = 1'b1;
        CFG_IMAG_START:    restart_saw = 1'b1;
        CFG_PHASE_STEP:    ;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_RESET;
      step_q    <= STEP_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_idx == CFG_WINDOW_LENGTH) begin
        win_len_q <= cfg_i.data[WIN_W-1:0];
      end
      if (cfg_idx == CFG_PHASE_STEP) begin
        step_q <= cfg_i.data[STEP_W-1:0];
      end
    end
  end

  // A zero window acts as one; a window beyond the history depth is clamped to it.
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(win_len_q);
    end
  end

  // Pipeline handshake. Each stage moves when the stage after it is empty or moving.
  logic s1_v_q, s2_v_q, out_v_q;
  logic accept, adv2, adv3;

  assign adv3           = s2_v_q && (!out_v_q || result_o.ready);
  assign adv2           = s1_v_q && (!s2_v_q || adv3);
  assign sample_i.ready = !s1_v_q || adv2;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (adv2) begin
        s1_v_q <= 1'b0;
      end
      if (adv2) begin
        s2_v_q <= 1'b1;
      end else if (adv3) begin
        s2_v_q <= 1'b0;
      end
      if (adv3) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Sawtooth references step once per accepted sample.
  logic signed [SAW_W-1:0] saw_re, saw_im;

  swc_saw_gen u_saw_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (accept),
    .step_i     (step_q),
    .restart_i  (restart_saw),
    .start_i    ($signed(cfg_i.data[START_W-1:0])),
    .saw_real_o (saw_re),
    .saw_imag_o (saw_im)
  );

  // Input stage: sample and the wrapped references it is multiplied with.
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic signed [SAW_W-1:0]       s1_saw_re_q, s1_saw_im_q;
  // Multiply stage: the two products.
  logic signed [PROD_W-1:0]      p_re_q, p_im_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i.sample;
      s1_saw_re_q <= saw_re;
      s1_saw_im_q <= saw_im;
    end
    if (adv2) begin
      p_re_q <= PROD_W'(s1_sample_q) * PROD_W'(s1_saw_re_q);
      p_im_q <= PROD_W'(s1_sample_q) * PROD_W'(s1_saw_im_q);
    end
  end

  // Product history: the product that leaves the window lines up with the multiply stage.
  hist_ctrl_t               hist_ctrl;
  logic signed [PROD_W-1:0] old_re, old_im;

  assign hist_ctrl.clear    = clear_win;
  assign hist_ctrl.push     = accept;
  assign hist_ctrl.s2_valid = s2_v_q;
  assign hist_ctrl.adv2     = adv2;
  assign hist_ctrl.adv3     = adv3;

  swc_win_mem #(
    .MAX_WINDOW (MAX_WINDOW),
    .PROD_W     (PROD_W)
  ) u_win_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (hist_ctrl),
    .len_i    (eff_len),
    .wr_re_i  (p_re_q),
    .wr_im_i  (p_im_q),
    .old_re_o (old_re),
    .old_im_o (old_im)
  );

  // Running sums add the newest product and drop the one leaving the window. They
  // wrap modulo 2^44 and double as the output register.
  logic signed [OUT_W-1:0] run_re_q, run_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_re_q <= '0;
      run_im_q <= '0;
    end else if (clear_win) begin
      run_re_q <= '0;
      run_im_q <= '0;
    end else if (adv3) begin
      run_re_q <= run_re_q + OUT_W'(p_re_q) - OUT_W'(old_re);
      run_im_q <= run_im_q + OUT_W'(p_im_q) - OUT_W'(old_im);
    end
  end

  assign result_o.valid    = out_v_q;
  assign result_o.sum_real = run_re_q;
  assign result_o.sum_imag = run_im_q;

endmodule

// ----- design/swc_checker.sv -----
// Port-level checker for the sawtooth window correlator, bound to the top level.
// Depends on swc_pkg and sawtooth_window_correlator_top_assert.svh.
`include "sawtooth_window_correlator_top_assert.svh"

module swc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [swc_pkg::OUT_W-1:0]   sum_real_i,
  input logic [swc_pkg::OUT_W-1:0]   sum_imag_i
);
  import swc_pkg::*;

  // Samples taken whose results have not yet been delivered.
  logic [2:0] inflight_q;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  `SWC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(sum_real_i) && $stable(sum_imag_i), "stalled result changed")
  `SWC_ASSERT_IMP(a_no_invented, clk_i, rst_ni, out_valid_i, inflight_q != 3'd0, "result without a pending sample")
  `SWC_ASSERT_IMP(a_depth, clk_i, rst_ni, 1'b1, inflight_q <= 3'd3, "more samples in flight than stages")
  `SWC_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, inflight_q == 3'd0, in_ready_i, "empty block refuses a sample")

endmodule

bind sawtooth_window_correlator_top swc_checker u_swc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .sum_real_i  (result_o.sum_real),
  .sum_imag_i  (result_o.sum_imag)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sawtooth_window_correlator_top, with its own model of the
// sawtooth references and the sliding window sums. Depends on swc_pkg, the swc_if channel
// interfaces and the design files.
module testbench;
  import swc_pkg::*;

  localparam int unsigned HIST_DEPTH   = 1024;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned RANDOM_ITEMS = 1850;
  // Settle time on top of the pipeline depth before touching registers.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Model of the correlator: both sawtooth references, the product history ring and the
  // running sums, plus the queue of sum pairs still owed by the block.
  class corr_scoreboard;
    logic [WIN_W-1:0]         win_len;
    logic [STEP_W-1:0]        step_sz;
    logic [START_W-1:0]       start_val;
    logic signed [SAW_W-1:0]  saw_re;
    logic signed [SAW_W-1:0]  saw_im;
    longint                   hist_re[HIST_DEPTH];
    longint                   hist_im[HIST_DEPTH];
    logic [9:0]               ptr;
    longint                   acc_re;
    longint                   acc_im;
    logic [OUT_W-1:0]         due_re[$];
    logic [OUT_W-1:0]         due_im[$];
    int unsigned              n_samples;
    int unsigned              n_sums;
    int unsigned              n_writes;
    int unsigned              n_errors;

    function new();
      win_len   = WIN_RESET;
      step_sz   = STEP_RESET;
      start_val = IMAG_RESET[START_W-1:0];
      saw_re    = '0;
      saw_im    = IMAG_RESET;
      clear_window();
    endfunction

    function void clear_window();
      foreach (hist_re[i]) begin
        hist_re[i] = 0;
        hist_im[i] = 0;
      end
      ptr    = '0;
      acc_re = 0;
      acc_im = 0;
    endfunction

    // Window length actually summed: zero counts as one, oversize is clamped.
    function logic [WIN_W-1:0] window_span();
      if (win_len == 0) return WIN_W'(1);
      if (win_len > HIST_DEPTH) return WIN_W'(HIST_DEPTH);
      return win_len;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        CFG_WINDOW_LENGTH: begin
          win_len = data[WIN_W-1:0];
          clear_window();
        end
        CFG_PHASE_STEP: step_sz = data[STEP_W-1:0];
        CFG_IMAG_START: begin
          start_val = data[START_W-1:0];
          saw_re    = '0;
          saw_im    = {start_val[START_W-1], start_val};
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SMP_W-1:0] s);
      logic [WIN_W-1:0] len;
      logic [9:0]       old_idx;
      longint           p_re;
      longint           p_im;
      len = window_span();
      if (saw_re < SAW_NEG_FS) saw_re = saw_re + SAW_WRAP;
      if (saw_im < SAW_NEG_FS) saw_im = saw_im + SAW_WRAP;
      p_re = longint'(s) * longint'(saw_re);
      p_im = longint'(s) * longint'(saw_im);
      saw_re = saw_re - $signed({2'b00, step_sz});
      saw_im = saw_im - $signed({2'b00, step_sz});
      // A full-depth window drops the entry that is about to be overwritten.
      old_idx = ptr - len[9:0];
      acc_re  = acc_re + p_re - hist_re[old_idx];
      acc_im  = acc_im + p_im - hist_im[old_idx];
      hist_re[ptr] = p_re;
      hist_im[ptr] = p_im;
      ptr = ptr + 1'b1;
      due_re.push_back(acc_re[OUT_W-1:0]);
      due_im.push_back(acc_im[OUT_W-1:0]);
      n_samples++;
    endfunction

    task report(string what);
      $display("[%0t ns] ERROR %s", $realtime, what);
      n_errors++;
    endtask

    task check_sums(logic [OUT_W-1:0] got_re, logic [OUT_W-1:0] got_im);
      logic [OUT_W-1:0] want_re;
      logic [OUT_W-1:0] want_im;
      n_sums++;
      if (due_re.size() == 0) begin
        report("sum beat arrived with no sample outstanding");
      end else begin
        want_re = due_re.pop_front();
        want_im = due_im.pop_front();
        if (got_re !== want_re)
          report($sformatf("sum %0d: sum_real %h, model %h", n_sums, got_re, want_re));
        if (got_im !== want_im)
          report($sformatf("sum %0d: sum_imag %h, model %h", n_sums, got_im, want_im));
      end
    endtask

    function int unsigned pending();
      return due_re.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  swc_sample_if #(.SAMPLE_BITS(SMP_W)) smp_if ();
  swc_result_if                        res_if ();
  swc_cfg_if                           cfg_if ();

  sawtooth_window_correlator_top #(
    .MAX_WINDOW (HIST_DEPTH),
    .SAMPLE_BITS(SMP_W)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .sample_i(smp_if),
    .result_o(res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  corr_scoreboard sb = new();

  // Per-phase stall modes for the two data channels; a phase may run with neither side
  // stalling, so back-to-back beats are covered as well as sparse traffic.
  bit          smp_idle;
  bit          res_idle;
  int unsigned n_sent;
  int unsigned quiet_cycles = 0;

  // All observation happens here, at the rising edge. Register beats are applied before
  // sample beats and sample beats before result beats, so the model order never depends
  // on which process the simulator wakes first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.apply_reg(cfg_if.index, cfg_if.data);
      if (smp_if.valid && smp_if.ready) sb.note_sample(smp_if.sample);
      if (res_if.valid && res_if.ready) sb.check_sums(res_if.sum_real, res_if.sum_imag);
      if ((cfg_if.valid && cfg_if.ready) || (smp_if.valid && smp_if.ready) ||
          (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A hung handshake shows up as a long run of cycles without any beat.
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no beat on any channel for %0d cycles.", QUIET_LIMIT);
    $display("sawtooth_window_correlator_top: mismatch");
    $finish;
  end

  // Result side: before each beat, ready may be held low when the phase stalls results.
  initial begin : result_sink
    int unsigned hold;
    res_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      hold = res_idle ? $urandom_range(0, 9) : 0;
      if (hold != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      @(negedge clk_i);
    end
  end

  function automatic void pick_idle_mode();
    logic [1:0] m;
    m = 2'($urandom_range(0, 3));
    smp_idle = m[0];
    res_idle = m[1];
  endfunction

  // Drives one sample beat; entered and left at a falling edge with valid still high, so
  // a following beat with no gap keeps valid up without a glitch.
  task automatic put_sample(input logic [SMP_W-1:0] s);
    int unsigned gap;
    gap = smp_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Caller lowers cfg_if.valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // Stops the sample stream and waits until every owed sum has come back and the
  // pipeline has had time to empty.
  task automatic quiesce();
    smp_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SMP_W'($urandom_range(0, 16) - 8);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Mostly short windows so that tails stay cheap; now and then the clamped extremes,
  // a long window, or a raw word with junk above the length field.
  function automatic logic [CFG_DATA_W-1:0] pick_window();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CFG_DATA_W'(HIST_DEPTH);
      2:       return 17'h1FFFF;
      3:       return CFG_DATA_W'($urandom_range(17, HIST_DEPTH));
      4:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'h0FFFF;
      2, 3:    return CFG_DATA_W'($urandom_range(1, 4096));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Start phase: usually within full scale, sometimes anywhere the 17-bit field reaches.
  function automatic logic [CFG_DATA_W-1:0] pick_start();
    case ($urandom_range(0, 7))
      0:       return 17'h18000;
      1:       return 17'h08000;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 65536) - 32768);
    endcase
  endfunction

  // One random phase: idle, rewrite some registers, stream samples, then flush the window
  // with zeros when it is short enough to make the tail cheap.
  task automatic random_phase();
    int unsigned n_items;
    logic [WIN_W-1:0] span;
    quiesce();
    pick_idle_mode();
    if ($urandom_range(0, 1)) write_reg(CFG_WINDOW_LENGTH, pick_window());
    if ($urandom_range(0, 1)) write_reg(CFG_PHASE_STEP, pick_step());
    if ($urandom_range(0, 1)) write_reg(CFG_IMAG_START, pick_start());
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    n_items = $urandom_range(20, 120);
    repeat (n_items) put_sample(pick_sample());
    span = sb.window_span();
    if (span <= 32) repeat (span - 1) put_sample('0);
  endtask

  initial begin : stimulus
    int unsigned n_directed;
    int unsigned n_phases;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    smp_idle      = 1'b0;
    res_idle      = 1'b0;
    n_sent        = 0;
    n_phases      = 0;
    rst_ni        = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: full-scale, unit and alternating-bit samples.
    pick_idle_mode();
    put_sample(16'h7FFF);
    put_sample(16'h8000);
    put_sample(16'hFFFF);
    put_sample(16'h0000);
    put_sample(16'h0001);
    put_sample(16'h5555);
    put_sample(16'hAAAA);

    // Window length zero acts as one; zero step freezes both references; the quadrature
    // one starts well above full scale.
    quiesce();
    pick_idle_mode();
    write_reg(CFG_WINDOW_LENGTH, 17'h00000);
    write_reg(CFG_PHASE_STEP, 17'h00000);
    write_reg(CFG_IMAG_START, 17'h0FFFF);
    cfg_if.valid <= 1'b0;
    put_sample(16'h7FFF);
    put_sample(16'h8000);
    put_sample(16'h3039);

    // Oversize window clamps to the full history; largest step; most negative start, so
    // the first sample already sees a wrap.
    quiesce();
    pick_idle_mode();
    write_reg(CFG_WINDOW_LENGTH, 17'h1FFFF);
    write_reg(CFG_PHASE_STEP, 17'h0FFFF);
    write_reg(CFG_IMAG_START, 17'h10000);
    cfg_if.valid <= 1'b0;
    put_sample(16'h8000);
    put_sample(16'h8000);
    put_sample(16'h7FFF);
    put_sample(16'h7FFF);
    put_sample(16'hFFFF);

    // Write to an unused register index, then a short window flushed by zero tail samples.
    quiesce();
    pick_idle_mode();
    write_reg(CFG_SPARE_IDX, 17'h1FFFF);
    write_reg(CFG_WINDOW_LENGTH, 17'd3);
    write_reg(CFG_PHASE_STEP, 17'd16384);
    write_reg(CFG_IMAG_START, 17'h08000);
    cfg_if.valid <= 1'b0;
    put_sample(16'd100);
    put_sample(-16'sd200);
    put_sample(16'h7FFF);
    put_sample(16'h0000);
    put_sample(16'h0000);
    n_directed = n_sent;

    while (n_sent < n_directed + RANDOM_ITEMS) begin
      random_phase();
      n_phases++;
    end

    quiesce();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d sums never arrived", sb.pending()));
    $display("Sent %0d samples (%0d directed) and checked %0d sum beats.",
             sb.n_samples, n_directed, sb.n_sums);
    $display("Applied %0d register writes over %0d random configuration phases.",
             sb.n_writes, n_phases);
    if (sb.n_errors == 0)
      $display("sawtooth_window_correlator_top: match");
    else
      $display("sawtooth_window_correlator_top: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/swc_pkg.sv
design/swc_if.sv
design/swc_saw_gen.sv
design/swc_win_mem.sv
design/sawtooth_window_correlator_top.sv
design/swc_checker.sv
dv/testbench.sv
